>>> rtl/mld_pkg.sv
// ============================================================================
// mld_pkg - shared definitions for the magic-length deframer
// Field widths, register map and reset values used by the deframer and
// its port checker.
// ============================================================================
package mld_pkg;

    // Field widths
    localparam int BYTE_W      = 8;
    localparam int FRAME_LEN_W = 16;
    localparam int LENGTH_BITS = 16;

    // Stream payload widths
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 2;

    // Bit positions in the master-side tuser
    localparam int USER_FIRST = 0;
    localparam int USER_EMPTY = 1;

    // APB register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_MAGIC_FIRST  = 2'd0;
    localparam logic [1:0] REG_MAGIC_SECOND = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd2;

    // Register reset values
    localparam logic [BYTE_W-1:0]      MAGIC_FIRST_RST  = 8'd148;
    localparam logic [BYTE_W-1:0]      MAGIC_SECOND_RST = 8'd195;
    localparam logic [FRAME_LEN_W-1:0] MAX_PAYLOAD_RST  = 16'd4096;

endpackage

>>> rtl/magic_length_deframer.sv
// ============================================================================
// magic_length_deframer - sync-word / length-prefixed byte deframer
// Hunts a two-byte sync pair, reads a big-endian length, and passes the
// payload bytes out with first, last and empty-frame marks.
// ============================================================================
// Usage: the block takes one received byte per clock on the slave side while
// s_tready is high, and gives at most one result per byte on the master side in the
// cycle after the byte is taken. All header and payload decisions are one small
// state update per byte, so the sustained rate is one byte per cycle while m_tready
// keeps up. A single output register sits between the two sides: s_tready drops
// only while a result is held and m_tready is low. A header whose length exceeds
// max_payload is dropped and the three bytes behind its first sync byte are scanned
// again for a sync pair. A zero-length frame yields one result with first, last and
// empty set. The user must write registers over APB only while no frame is in
// flight, unenforced by the block; writes take effect on the next byte examined.
// ============================================================================
module magic_length_deframer #(
    parameter int LENGTH_BITS = mld_pkg::LENGTH_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Received bytes
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mld_pkg::S_DATA_W-1:0]    s_tdata,   // [7:0] rx_byte

    // Payload results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mld_pkg::M_DATA_W-1:0]    m_tdata,   // [7:0] payload_byte,
                                                       // [23:8] frame_length
    output logic                            m_tlast,   // frame_last
    output logic [mld_pkg::M_USER_W-1:0]    m_tuser,   // [0] frame_first,
                                                       // [1] frame_empty

    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mld_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mld_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mld_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int BW = mld_pkg::BYTE_W;
    localparam int FW = mld_pkg::FRAME_LEN_W;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SYNC1 = 3'd1,
        PH_LENHI = 3'd2,
        PH_LENLO = 3'd3,
        PH_DATA  = 3'd4
    } phase_t;

    // Configuration registers
    logic [BW-1:0] magic_first_reg;
    logic [BW-1:0] magic_second_reg;
    logic [FW-1:0] max_payload_reg;

    // Deframer state
    phase_t                 phase_reg, phase_next;
    logic [BW-1:0]          len_hi_reg, len_hi_next;
    logic [BW-1:0]          len_lo_reg, len_lo_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic [LENGTH_BITS-1:0] total_reg, total_next;

    // Result register
    logic          out_valid_reg;
    logic [BW-1:0] out_byte_reg;
    logic          out_first_reg;
    logic          out_last_reg;
    logic          out_empty_reg;
    logic [FW-1:0] out_len_reg;

    // Result of the current byte
    logic                   res_valid;
    logic [BW-1:0]          res_byte;
    logic                   res_first;
    logic                   res_last;
    logic                   res_empty;
    logic [LENGTH_BITS-1:0] res_len;

    logic                   in_accept;
    logic                   cfg_write;
    logic [1:0]             cfg_sel;
    logic [BW-1:0]          rx_byte;
    logic [FW-1:0]          hdr_word;
    logic [LENGTH_BITS-1:0] hdr_len;
    logic [LENGTH_BITS-1:0] left_dec;

    assign rx_byte   = s_tdata[BW-1:0];
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    // APB access
    assign pready    = 1'b1;
    assign cfg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_sel)
            mld_pkg::REG_MAGIC_FIRST:  prdata = 32'(magic_first_reg);
            mld_pkg::REG_MAGIC_SECOND: prdata = 32'(magic_second_reg);
            mld_pkg::REG_MAX_PAYLOAD:  prdata = 32'(max_payload_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_first_reg  <= mld_pkg::MAGIC_FIRST_RST;
            magic_second_reg <= mld_pkg::MAGIC_SECOND_RST;
            max_payload_reg  <= mld_pkg::MAX_PAYLOAD_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                mld_pkg::REG_MAGIC_FIRST:  magic_first_reg  <= pwdata[BW-1:0];
                mld_pkg::REG_MAGIC_SECOND: magic_second_reg <= pwdata[BW-1:0];
                mld_pkg::REG_MAX_PAYLOAD:  max_payload_reg  <= pwdata[FW-1:0];
                default:                   ;
            endcase
        end
    end

    // Header length, masked to the configured length width
    assign hdr_word = {len_hi_reg, rx_byte};
    assign hdr_len  = hdr_word[LENGTH_BITS-1:0];
    assign left_dec = (left_reg != '0) ? left_reg - 1'b1 : left_reg;

    // Per-byte state update
    always_comb
    begin
        phase_next = phase_reg;
        len_hi_next = len_hi_reg;
        len_lo_next = len_lo_reg;
        left_next   = left_reg;
        total_next  = total_reg;
        res_valid   = 1'b0;
        res_byte    = rx_byte;
        res_first   = 1'b0;
        res_last    = 1'b0;
        res_empty   = 1'b0;
        res_len     = total_reg;

        case (phase_reg)
            PH_SYNC1:
            begin
                if (rx_byte == magic_second_reg)
                    phase_next = PH_LENHI;
                else if (rx_byte == magic_first_reg)
                    phase_next = PH_SYNC1;
                else
                    phase_next = PH_IDLE;
            end

            PH_LENHI:
            begin
                len_hi_next = rx_byte;
                phase_next  = PH_LENLO;
            end

            PH_LENLO:
            begin
                len_lo_next = rx_byte;
                if (FW'(hdr_len) > max_payload_reg)
                begin
                    // Rejected header: rescan second sync, length high, length low
                    if (magic_second_reg == magic_first_reg &&
                        len_hi_reg == magic_second_reg)
                    begin
                        len_hi_next = rx_byte;
                        phase_next  = PH_LENLO;
                    end
                    else if (len_hi_reg == magic_first_reg &&
                             rx_byte == magic_second_reg)
                        phase_next = PH_LENHI;
                    else if (rx_byte == magic_first_reg)
                        phase_next = PH_SYNC1;
                    else
                        phase_next = PH_IDLE;
                end
                else
                begin
                    total_next = hdr_len;
                    left_next  = hdr_len;
                    if (hdr_len == '0)
                    begin
                        // Empty frame: one marker result
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_byte   = '0;
                        res_first  = 1'b1;
                        res_last   = 1'b1;
                        res_empty  = 1'b1;
                        res_len    = '0;
                    end
                    else
                        phase_next = PH_DATA;
                end
            end

            PH_DATA:
            begin
                res_valid = 1'b1;
                res_first = (left_reg == total_reg);
                res_last  = (left_reg <= LENGTH_BITS'(1));
                left_next = left_dec;
                if (left_dec == '0)
                    phase_next = PH_IDLE;
            end

            default:
            begin
                phase_next = (rx_byte == magic_first_reg) ? PH_SYNC1 : PH_IDLE;
            end
        endcase
    end

    // Hold state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            len_hi_reg    <= '0;
            len_lo_reg    <= '0;
            left_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg  <= phase_next;
                len_hi_reg <= len_hi_next;
                len_lo_reg <= len_lo_next;
                left_reg   <= left_next;
                total_reg  <= total_next;
            end
            if (in_accept && res_valid)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (in_accept && res_valid)
        begin
            out_byte_reg  <= res_byte;
            out_first_reg <= res_first;
            out_last_reg  <= res_last;
            out_empty_reg <= res_empty;
            out_len_reg   <= FW'(res_len);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_empty_reg, out_first_reg};

endmodule

>>> rtl/mld_checker.sv
// ============================================================================
// mld_checker - port-level checks for the magic-length deframer
// Watches the stream ports and flags frame marks that cannot occur.
// ============================================================================
module mld_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mld_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                          m_tlast,
    input logic [mld_pkg::M_USER_W-1:0]  m_tuser
);

    localparam int BW = mld_pkg::BYTE_W;
    localparam int FW = mld_pkg::FRAME_LEN_W;

    logic          frm_first;
    logic          frm_empty;
    logic [FW-1:0] frm_len;

    assign frm_first = m_tuser[mld_pkg::USER_FIRST];
    assign frm_empty = m_tuser[mld_pkg::USER_EMPTY];
    assign frm_len   = m_tdata[BW +: FW];

    // Stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tlast) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Empty frame is a lone zero beat
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && frm_empty |-> m_tlast && frm_first &&
                                  m_tdata[BW-1:0] == '0 && frm_len == '0)
        else $error("malformed empty-frame beat");

    // Payload beats carry a nonzero length
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !frm_empty |-> frm_len != '0)
        else $error("payload beat with zero length");

    // Single-byte frame starts and ends on the same beat
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && frm_first && frm_len == FW'(1) |-> m_tlast)
        else $error("one-byte frame without last mark");

    // Input side open whenever no result is held
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind magic_length_deframer mld_checker u_mld_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
